// ===== design/ber_tlv_tag_search_assert.svh =====
// assertion macros for the tag search block
`ifndef BER_TLV_TAG_SEARCH_ASSERT_SVH
`define BER_TLV_TAG_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
`define BTTS_CHECK(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define BTTS_IMPLY_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BTTS_CHECK(lbl, clk, rst_n, expr, msg)
`define BTTS_IMPLY_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/btts_pkg.sv =====
package btts_pkg;

	localparam logic [4:0] TAG_MULTI = 5'h1F;
	localparam logic [7:0] LEN_LONG = 8'h80;
	localparam logic [6:0] LEN_MASK = 7'h7F;
	localparam logic [7:0] CONS_BIT = 8'h20;
	localparam logic [7:0] PAD_BYTE = 8'h00;
	localparam logic [15:0] WANTED_RST = 16'h005A;
	localparam int DEPTH_W = 5;
	localparam int REM_W = 16;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [12:0] bytes_left;
		logic first_byte;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] element_tag;
		logic [15:0] element_length;
		logic header_done;
		logic constructed;
		logic [3:0] nest_depth;
		logic [7:0] value_byte;
		logic in_match;
		logic match_last;
		logic found;
		logic malformed;
		logic search_failed;
		logic done_res;
	} out_beat_t;

	typedef struct packed {
		logic step;
		logic descend;
		logic pop_one;
		logic pop_ended;
		logic [15:0] len;
	} stk_cmd_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic [REM_W-1:0] rem;
	} stk_stat_t;

endpackage

// ===== design/btts_level_stack.sv =====
`include "ber_tlv_tag_search_assert.svh"

module btts_level_stack #(
	parameter int MAX_DEPTH = 8,
	parameter int BUF_BYTES = 4096
) (
	input logic clk,
	input logic arst_n,
	input logic restart,
	input logic [btts_pkg::REM_W-1:0] top_rem,
	input btts_pkg::stk_cmd_t cmd,
	output btts_pkg::stk_stat_t stat
);
	import btts_pkg::*;

	localparam int PW = $clog2(MAX_DEPTH + 1);
	localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int RW = $clog2(BUF_BYTES);

	logic [PW-1:0] ptr_q;
	logic [RW-1:0] rem_q [MAX_DEPTH];

	logic [PW-1:0] ptr_c, ptr_n, ptr_f;
	logic [IW-1:0] idx;
	logic [RW-1:0] rem_c, r_cur;
	logic [RW-1:0] rem_nxt [MAX_DEPTH];

	always_comb begin
		ptr_c = restart ? '0 : ptr_q;
		idx = IW'(ptr_c - PW'(1));
		rem_c = rem_q[idx];
		if (ptr_c == '0) begin
			r_cur = RW'(top_rem);
		end else if (rem_c != '0) begin
			r_cur = rem_c - RW'(1);
		end else begin
			r_cur = '0;
		end

		stat.depth = DEPTH_W'(ptr_c);
		stat.rem = REM_W'(r_cur);
	end

	always_comb begin
		rem_nxt = rem_q;
		ptr_n = ptr_c;
		if (ptr_c != '0) begin
			rem_nxt[idx] = r_cur;
		end
		if (cmd.descend) begin
			if (ptr_c != '0) begin
				rem_nxt[idx] = r_cur - RW'(cmd.len);
			end
			rem_nxt[IW'(ptr_c)] = RW'(cmd.len);
			ptr_n = ptr_c + PW'(1);
		end else if (cmd.pop_one) begin
			ptr_n = ptr_c - PW'(1);
		end

		// close the run-out levels above the deepest level that still has bytes left, innermost first
		ptr_f = ptr_n;
		if (cmd.pop_ended) begin
			ptr_f = '0;
			for (int k = 1; k <= MAX_DEPTH; k++) begin
				if (PW'(k) <= ptr_n && rem_nxt[k-1] != '0) begin
					ptr_f = PW'(k);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.step) begin
			ptr_q <= ptr_f;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			rem_q <= rem_nxt;
		end
	end

	`BTTS_CHECK(a_ptr_bound, clk, arst_n, ptr_q <= PW'(MAX_DEPTH), "level pointer past max depth")
	`BTTS_IMPLY_NEXT(a_descend_nonzero, clk, arst_n, cmd.step && cmd.descend, ptr_q != '0, "descent left pointer at top")

endmodule

// ===== design/ber_tlv_tag_search.sv =====
// streaming tag search over one byte per beat
// the result beat is registered in the cycle after the input beat is taken
// throughput: one byte per cycle unless in_stall; level bookkeeping and pop search settle in that cycle
// reset: arst_n clears parse state, level pointer and output valid; wanted tag reverts to 0x005A
// first_byte restarts the search on the beat that carries it
`include "ber_tlv_tag_search_assert.svh"

module ber_tlv_tag_search #(
	parameter int MAX_DEPTH = 8,
	parameter int BUF_BYTES = 4096
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [15:0] cfg_wr_data,
	input logic in_valid,
	output logic in_stall,
	input btts_pkg::in_beat_t in_data,
	output logic out_valid,
	input logic out_stall,
	output btts_pkg::out_beat_t out_data
);
	import btts_pkg::*;

	typedef enum logic [2:0] {
		PH_PAD,
		PH_TAG2,
		PH_LEN1,
		PH_LENX,
		PH_SKIPVAL,
		PH_MATCH
	} phase_t;

	phase_t phase_q, ph_c, ph_n;
	logic [15:0] wanted_q;
	logic [15:0] tag_q, tag_c, tag_n;
	logic [15:0] len_q, len_c, len_n;
	logic [1:0] lbp_q, lbp_c, lbp_n;
	logic skip_q, skip_c, skip_n;
	logic [15:0] mrem_q, mrem_c, mrem_n;
	logic done_q, done_c, done_n;
	logic out_valid_q;
	out_beat_t out_data_q, o;

	logic acc;
	logic [16:0] bl;
	logic [REM_W-1:0] top_rem;
	logic [7:0] byte_in;
	logic [6:0] lol;
	logic [7:0] first_tag;
	logic [15:0] len_val;
	logic bad, hdr, cons, skip_val;
	stk_cmd_t cmd;
	stk_stat_t stat;

	assign in_stall = out_valid_q && out_stall;
	assign acc = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
	assign byte_in = in_data.data_byte;

	always_comb begin
		bl = {4'b0, in_data.bytes_left};
		if (bl == '0) begin
			bl = 17'd1;
		end
		if (bl > 17'(BUF_BYTES)) begin
			bl = 17'(BUF_BYTES);
		end
		top_rem = REM_W'(bl - 17'd1);
	end

	btts_level_stack #(
		.MAX_DEPTH(MAX_DEPTH),
		.BUF_BYTES(BUF_BYTES)
	) u_stack (
		.clk(clk),
		.arst_n(arst_n),
		.restart(in_data.first_byte),
		.top_rem(top_rem),
		.cmd(cmd),
		.stat(stat)
	);

	always_comb begin
		if (in_data.first_byte) begin
			ph_c = PH_PAD;
			tag_c = '0;
			len_c = '0;
			lbp_c = '0;
			skip_c = 1'b0;
			mrem_c = '0;
			done_c = 1'b0;
		end else begin
			ph_c = phase_q;
			tag_c = tag_q;
			len_c = len_q;
			lbp_c = lbp_q;
			skip_c = skip_q;
			mrem_c = mrem_q;
			done_c = done_q;
		end
		ph_n = ph_c;
		tag_n = tag_c;
		len_n = len_c;
		lbp_n = lbp_c;
		skip_n = skip_c;
		mrem_n = mrem_c;
		done_n = done_c;
		o = '0;
		cmd = '0;
		bad = 1'b0;
		hdr = 1'b0;
		len_val = '0;
		lol = byte_in[6:0];
		first_tag = (tag_c > 16'h00FF) ? tag_c[15:8] : tag_c[7:0];
		cons = (first_tag & CONS_BIT) != '0;
		skip_val = 1'b0;

		if (!done_c) begin
			o.nest_depth = 4'(stat.depth);
			if (ph_c == PH_MATCH) begin
				o.value_byte = byte_in;
				o.in_match = 1'b1;
				if (mrem_c != '0) begin
					mrem_n = mrem_c - 16'd1;
				end
				if (mrem_n == '0) begin
					o.match_last = 1'b1;
					done_n = 1'b1;
				end
			end else begin
				cmd.step = acc;
				if (skip_c) begin
					if (stat.rem == '0) begin
						skip_n = 1'b0;
						cmd.pop_one = 1'b1;
					end
				end else begin
					case (ph_c)
						PH_PAD: begin
							if (byte_in != PAD_BYTE) begin
								tag_n = {8'b0, byte_in};
								ph_n = (byte_in[4:0] == TAG_MULTI) ? PH_TAG2 : PH_LEN1;
							end
							if (stat.rem == '0) begin
								bad = 1'b1;
							end
						end
						PH_TAG2: begin
							tag_n = {tag_c[7:0], byte_in};
							ph_n = PH_LEN1;
							if (stat.rem == '0) begin
								bad = 1'b1;
							end
						end
						PH_LEN1: begin
							if ((byte_in & LEN_LONG) != '0) begin
								if (lol == '0 || lol > 7'd2) begin
									bad = 1'b1;
								end else begin
									lbp_n = lol[1:0];
									len_n = '0;
									ph_n = PH_LENX;
									if (stat.rem == '0) begin
										bad = 1'b1;
									end
								end
							end else begin
								hdr = 1'b1;
								len_val = {8'b0, byte_in & {1'b0, LEN_MASK}};
							end
						end
						PH_LENX: begin
							len_n = {len_c[7:0], byte_in};
							if (lbp_c != '0) begin
								lbp_n = lbp_c - 2'd1;
							end
							if (lbp_n == '0) begin
								hdr = 1'b1;
								len_val = len_n;
							end else if (stat.rem == '0) begin
								bad = 1'b1;
							end
						end
						PH_SKIPVAL: begin
							if (len_c != '0) begin
								len_n = len_c - 16'd1;
							end
							if (len_n == '0) begin
								ph_n = PH_PAD;
							end
						end
						default: begin
							ph_n = PH_PAD;
						end
					endcase
				end

				if (hdr) begin
					if (len_val > stat.rem) begin
						bad = 1'b1;
					end else begin
						o.element_tag = tag_c;
						o.element_length = len_val;
						o.header_done = 1'b1;
						o.constructed = cons;
						ph_n = PH_PAD;
						if (tag_c == wanted_q) begin
							o.found = 1'b1;
							if (len_val == '0) begin
								done_n = 1'b1;
							end else begin
								ph_n = PH_MATCH;
								mrem_n = len_val;
							end
						end else if (cons) begin
							if (stat.depth < DEPTH_W'(MAX_DEPTH)) begin
								if (len_val != '0) begin
									cmd.descend = 1'b1;
									cmd.len = len_val;
								end
							end else begin
								o.malformed = 1'b1;
								skip_val = 1'b1;
							end
						end else begin
							skip_val = 1'b1;
						end
						if (skip_val && len_val != '0) begin
							len_n = len_val;
							ph_n = PH_SKIPVAL;
						end
					end
				end

				if (bad) begin
					o.malformed = 1'b1;
					ph_n = PH_PAD;
					lbp_n = '0;
					if (stat.depth == '0) begin
						o.search_failed = 1'b1;
						done_n = 1'b1;
					end else if (stat.rem == '0) begin
						cmd.pop_one = 1'b1;
					end else begin
						skip_n = 1'b1;
					end
				end

				cmd.pop_ended = !done_n && !skip_n && ph_n == PH_PAD;
			end

			if (!done_n && bl <= 17'd1) begin
				o.search_failed = 1'b1;
				done_n = 1'b1;
			end
		end
		o.done_res = done_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_q <= WANTED_RST;
			phase_q <= PH_PAD;
			tag_q <= '0;
			len_q <= '0;
			lbp_q <= '0;
			skip_q <= 1'b0;
			mrem_q <= '0;
			done_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				wanted_q <= cfg_wr_data;
			end
			if (acc) begin
				phase_q <= ph_n;
				tag_q <= tag_n;
				len_q <= len_n;
				lbp_q <= lbp_n;
				skip_q <= skip_n;
				mrem_q <= mrem_n;
				done_q <= done_n;
				out_data_q <= o;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`BTTS_IMPLY_NEXT(a_done_quiet, clk, arst_n, acc && done_q && !in_data.first_byte, out_valid_q && out_data_q.done_res && !out_data_q.in_match && !out_data_q.header_done, "beat after finish not quiet")
	`BTTS_IMPLY_NEXT(a_match_beat, clk, arst_n, acc && phase_q == PH_MATCH && !done_q && !in_data.first_byte, out_data_q.in_match, "value beat not flagged in match")
	`BTTS_IMPLY_NEXT(a_buf_end, clk, arst_n, acc && in_data.bytes_left <= 13'd1, out_data_q.done_res, "buffer end without finish")

endmodule
